@@ sv/lsr_pkg.sv @@
// Package for the LIN slave responder: phase codes, item kinds, the sync byte,
// the store write request type and the protected identifier function.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package lsr_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned ID_W   = 6;
   localparam int unsigned SLOT_W = 2;

   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;

   // Item kinds carried in the func field.
   localparam logic FUNC_RX_BYTE    = 1'b0;
   localparam logic FUNC_SLOT_WRITE = 1'b1;

   // Link phase; the fourth code is never reached and decodes as break wait.
   typedef enum logic [1:0] {
      PH_BREAK = 2'd0,
      PH_SYNC  = 2'd1,
      PH_PID   = 2'd2
   } phase_type;

   // Write request from the controller to the data store.
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [BYTE_W-1:0] value;
   } wr_req_type;

   // Protected identifier: P0 in bit 6, P1 (inverted parity) in bit 7.
   function automatic logic [BYTE_W-1:0] make_pid(input logic [ID_W-1:0] id);
      logic p0;
      logic p1;
      p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
      p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
      return {p1, p0, id};
   endfunction

endpackage

`default_nettype wire

@@ sv/lsr_if.sv @@
// Handshake channel interfaces of the LIN slave responder: the request
// channel (received bytes and slot writes) and the response channel.
// Depends on lsr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lsr_req_if;
   import lsr_pkg::*;

   logic              valid;
   logic              ready;
   logic              func;
   logic [BYTE_W-1:0] rx_byte;
   logic              framing_error;
   logic [SLOT_W-1:0] slot_index;
   logic [BYTE_W-1:0] slot_value;

   modport source (output valid, func, rx_byte, framing_error, slot_index, slot_value,
                   input ready);
   modport sink   (input valid, func, rx_byte, framing_error, slot_index, slot_value,
                   output ready);
endinterface

interface lsr_rsp_if;
   import lsr_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] tx_byte;
   logic              tx_valid;
   logic              last_byte;
   logic              break_seen;

   modport source (output valid, tx_byte, tx_valid, last_byte, break_seen, input ready);
   modport sink   (input valid, tx_byte, tx_valid, last_byte, break_seen, output ready);
endinterface

`default_nettype wire

@@ sv/lin_slave_responder_top.sv @@
// Top level of the LIN slave responder: controller plus response data store.
// Depends on lsr_pkg, lsr_if, lsr_store and lsr_ctrl.
//
// The request channel carries one transaction per received UART byte (func 0,
// with its framing-error flag) or per data slot write (func 1). The slave
// waits for a break, then the sync byte 0x55, then the protected identifier
// built from the node identifier written through csr_wdata. A break produces
// one response transaction with break_seen set. A matching identifier produces
// DATA_BYTES data transactions followed by the enhanced checksum, marked by
// last_byte. A break report is presented the cycle after acceptance and holds the
// request channel until it is taken. For a frame response each data byte is first
// read from the store, then presented from the output register; the checksum
// follows the last data byte.
// One request is handled at a time; the request channel reopens when the last
// response transaction is taken. Reset (synchronous, active high) returns to
// break wait, clears the node identifier and makes every data slot read as
// zero. A stalled receiver holds the pending transaction in the output register
// until it is taken. The identifier should only be written while idle.
`timescale 1ns / 1ps
`default_nettype none

module lin_slave_responder_top #(
   parameter int unsigned DATA_BYTES = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   lsr_req_if.sink                        req_if,
   lsr_rsp_if.source                      rsp_if,
   input  wire logic                      csr_we,
   input  wire logic [lsr_pkg::ID_W-1:0]  csr_wdata
);
   import lsr_pkg::*;

   // At least one address bit, even for a single data byte.
   localparam int unsigned IDX_W = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

   wr_req_type        wr_req;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [BYTE_W-1:0] rd_data;

   // Sequencer: phase tracking, PID check, output register and checksum.
   lsr_ctrl #(
      .DATA_BYTES (DATA_BYTES),
      .IDX_W      (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .wr_req    (wr_req),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // Data slots; writes happen only while idle, reads only on a matching identifier
   // or while answering, so the two never touch the store in the same cycle.
   lsr_store #(
      .DATA_BYTES (DATA_BYTES),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_req  (wr_req),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

@@ sv/lsr_store.sv @@
// Response data store of the LIN slave responder: a small synchronous memory
// with a registered read and per-entry valid bits that read as zero.
// Depends on lsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsr_store #(
   parameter int unsigned DATA_BYTES = 4,
   parameter int unsigned IDX_W      = 2
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire lsr_pkg::wr_req_type       wr_req,
   input  wire logic                      rd_en,
   input  wire logic [IDX_W-1:0]          rd_addr,
   output logic      [lsr_pkg::BYTE_W-1:0] rd_data
);
   import lsr_pkg::*;

   logic [BYTE_W-1:0]     mem [DATA_BYTES];
   logic [DATA_BYTES-1:0] vld_ff;
   logic [BYTE_W-1:0]     rd_data_ff;
   logic                  wr_hit;
   logic [IDX_W-1:0]      wr_addr;

   // Slots at or beyond the configured depth are dropped.
   assign wr_hit  = wr_req.en && ({2'b00, wr_req.slot} < 4'(DATA_BYTES));
   assign wr_addr = IDX_W'(wr_req.slot);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_hit) begin
         vld_ff[wr_addr] <= 1'b1;
      end
      if (wr_hit) begin
         mem[wr_addr] <= wr_req.value;
      end
      if (rd_en) begin
         rd_data_ff <= vld_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

`ifndef SYNTHESIS
   // Writes come only while idle and reads only during a response.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_req.en))
      else $error("store read and write in the same cycle");

   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (32'(rd_addr) < DATA_BYTES))
      else $error("store read beyond depth");

   a_vld_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(wr_hit) && !$past(reset) |-> vld_ff[$past(wr_addr)])
      else $error("written entry not marked valid");
`endif

endmodule

`default_nettype wire

@@ sv/lsr_ctrl.sv @@
// Frame controller of the LIN slave responder: link phase tracking, PID match,
// response sequencing over the data store and the enhanced checksum.
// Depends on lsr_pkg and the channel interfaces in lsr_if.
`timescale 1ns / 1ps
`default_nettype none

module lsr_ctrl #(
   parameter int unsigned DATA_BYTES = 4,
   parameter int unsigned IDX_W      = 2
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   lsr_req_if.sink                        req_if,
   lsr_rsp_if.source                      rsp_if,
   input  wire logic                      csr_we,
   input  wire logic [lsr_pkg::ID_W-1:0]  csr_wdata,
   output lsr_pkg::wr_req_type            wr_req,
   output logic                           rd_en,
   output logic      [IDX_W-1:0]          rd_addr,
   input  wire logic [lsr_pkg::BYTE_W-1:0] rd_data
);
   import lsr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DATA,
      ST_LAST
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_BYTES - 1);

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [ID_W-1:0]   node_id_ff, node_id_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] tx_byte_ff, tx_byte_in;
   logic              tx_valid_ff, tx_valid_in;
   logic              last_ff, last_in;
   logic              break_ff, break_in;

   logic              req_fire;
   logic              rsp_fire;
   logic [BYTE_W:0]   sum_wide;
   logic [BYTE_W-1:0] sum_add;

   assign req_fire = req_if.valid && (state_ff == ST_IDLE);
   assign rsp_fire = rsp_valid_ff && rsp_if.ready;

   // End-around carry: a carry out of bit 7 folds back into bit 0.
   assign sum_wide = {1'b0, sum_ff} + {1'b0, rd_data};
   assign sum_add  = sum_wide[BYTE_W] ? sum_wide[BYTE_W-1:0] + 8'd1 : sum_wide[BYTE_W-1:0];

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      tx_byte_in   = tx_byte_ff;
      tx_valid_in  = tx_valid_ff;
      last_in      = last_ff;
      break_in     = break_ff;
      node_id_in   = csr_we ? csr_wdata : node_id_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      wr_req.en    = 1'b0;
      wr_req.slot  = req_if.slot_index;
      wr_req.value = req_if.slot_value;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_if.func == FUNC_SLOT_WRITE) begin
                  wr_req.en = 1'b1;
               end else begin
                  case (phase_ff)
                     PH_SYNC: begin
                        phase_in = (req_if.rx_byte == SYNC_BYTE) ? PH_PID : PH_BREAK;
                     end
                     PH_PID: begin
                        phase_in = PH_BREAK;
                        if (req_if.rx_byte == make_pid(node_id_ff)) begin
                           sum_in   = req_if.rx_byte;
                           idx_in   = '0;
                           rd_en    = 1'b1;
                           rd_addr  = '0;
                           state_in = ST_READ;
                        end
                     end
                     default: begin
                        phase_in = PH_BREAK;
                        if (req_if.framing_error) begin
                           phase_in     = PH_SYNC;
                           rsp_valid_in = 1'b1;
                           tx_byte_in   = '0;
                           tx_valid_in  = 1'b0;
                           last_in      = 1'b0;
                           break_in     = 1'b1;
                           state_in     = ST_LAST;
                        end
                     end
                  endcase
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            tx_byte_in   = rd_data;
            tx_valid_in  = 1'b1;
            last_in      = 1'b0;
            break_in     = 1'b0;
            sum_in       = sum_add;
            state_in     = ST_DATA;
         end
         ST_DATA: begin
            if (rsp_fire) begin
               if (idx_ff == LAST_IDX) begin
                  tx_byte_in = ~sum_ff;
                  last_in    = 1'b1;
                  state_in   = ST_LAST;
               end else begin
                  idx_in       = idx_ff + 1'b1;
                  rd_en        = 1'b1;
                  rd_addr      = idx_ff + 1'b1;
                  rsp_valid_in = 1'b0;
                  state_in     = ST_READ;
               end
            end
         end
         ST_LAST: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
            state_in     = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_BREAK;
         node_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         node_id_ff   <= node_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      tx_byte_ff  <= tx_byte_in;
      tx_valid_ff <= tx_valid_in;
      last_ff     <= last_in;
      break_ff    <= break_in;
   end

   assign req_if.ready      = (state_ff == ST_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.tx_byte    = tx_byte_ff;
   assign rsp_if.tx_valid   = tx_valid_ff;
   assign rsp_if.last_byte  = last_ff;
   assign rsp_if.break_seen = break_ff;

`ifndef SYNTHESIS
   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rsp_valid_ff)
      else $error("response pending while idle");

   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_ff) |-> (tx_valid_ff && !break_ff))
      else $error("checksum marker on a non-data transaction");

   a_break_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && break_ff) |-> (!tx_valid_ff && phase_ff == PH_SYNC))
      else $error("break report without moving to sync wait");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAST && rsp_fire) |=> (state_ff == ST_IDLE))
      else $error("final transaction did not end the response");
`endif

endmodule

`default_nettype wire

@@ tb/lin_slave_responder_top_tb.sv @@
// Self-checking testbench for lin_slave_responder_top: break, sync and PID frame answering.
// Depends on lsr_pkg and lsr_if from the RTL. A response tracker class predicts and checks
// every response transaction.
`timescale 1ns / 1ps

module lin_slave_responder_top_tb;
   import lsr_pkg::*;

   // Four data slots, as in the block's default configuration.
   localparam int unsigned SLOTS = 4;
   // Settle time that is waited before a register write and before the end of the run.
   localparam int unsigned SETTLE = 2 * SLOTS + 8;
   // Cycles in a row with no transaction on either channel before the run is abandoned.
   localparam int unsigned STALL_LIMIT = 3000;

   typedef struct packed {
      logic              func;
      logic [BYTE_W-1:0] rx_byte;
      logic              framing_error;
      logic [SLOT_W-1:0] slot_index;
      logic [BYTE_W-1:0] slot_value;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] tx_byte;
      logic              tx_valid;
      logic              last_byte;
      logic              break_seen;
   } reply_type;

   // Follows the link phase, the node id and the data slots. It turns each
   // accepted request into the response transactions that the slave must send.
   class lin_reply_tracker;
      logic [ID_W-1:0]   node_id;
      phase_type         link_state;
      logic [BYTE_W-1:0] slots [SLOTS];
      reply_type         pending_replies [$];
      int unsigned       errors;
      int unsigned       frames_answered;
      int unsigned       breaks_seen;

      function new();
         node_id         = '0;
         link_state      = PH_BREAK;
         errors          = 0;
         frames_answered = 0;
         breaks_seen     = 0;
         foreach (slots[i]) slots[i] = '0;
      endfunction

      // P0 is the parity of id bits 0, 1, 2 and 4. P1 is the inverted parity of bits 1, 3, 4 and 5.
      function logic [BYTE_W-1:0] pid_for(input logic [ID_W-1:0] id);
         logic p0;
         logic p1;
         p0 = ^(id & 6'b010111);
         p1 = ~^(id & 6'b111010);
         return {p1, p0, id};
      endfunction

      // Enhanced checksum: the PID and all slots summed with end-around carry, then inverted.
      function logic [BYTE_W-1:0] frame_checksum(input logic [BYTE_W-1:0] pid);
         int unsigned acc;
         acc = pid;
         foreach (slots[i]) begin
            acc += slots[i];
            if (acc > 255) acc -= 255;
         end
         return ~acc[BYTE_W-1:0];
      endfunction

      function reply_type make_reply(input logic [BYTE_W-1:0] b, input logic v, input logic l,
                                     input logic s);
         reply_type rep;
         rep.tx_byte    = b;
         rep.tx_valid   = v;
         rep.last_byte  = l;
         rep.break_seen = s;
         return rep;
      endfunction

      function void note_request(input req_item_type r);
         logic [BYTE_W-1:0] pid;
         if (r.func == FUNC_SLOT_WRITE) begin
            if (r.slot_index < SLOTS) slots[r.slot_index] = r.slot_value;
            return;
         end
         case (link_state)
            PH_SYNC: begin
               if (r.rx_byte == SYNC_BYTE) link_state = PH_PID;
               else link_state = PH_BREAK;
            end
            PH_PID: begin
               link_state = PH_BREAK;
               pid = pid_for(node_id);
               if (r.rx_byte == pid) begin
                  foreach (slots[i]) pending_replies.push_back(make_reply(slots[i], 1, 0, 0));
                  pending_replies.push_back(make_reply(frame_checksum(pid), 1, 1, 0));
                  frames_answered++;
               end
            end
            default: begin
               link_state = PH_BREAK;
               if (r.framing_error) begin
                  link_state = PH_SYNC;
                  pending_replies.push_back(make_reply('0, 0, 0, 1));
                  breaks_seen++;
               end
            end
         endcase
      endfunction

      // Prints one line per mismatch and counts it.
      task report_mismatch(input string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_reply(input reply_type got);
         reply_type exp;
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected response byte %02h valid %0b last %0b brk %0b",
                                      got.tx_byte, got.tx_valid, got.last_byte, got.break_seen));
            return;
         end
         exp = pending_replies.pop_front();
         if (got.tx_byte !== exp.tx_byte)
            report_mismatch($sformatf("tx_byte %02h, want %02h", got.tx_byte, exp.tx_byte));
         if (got.tx_valid !== exp.tx_valid)
            report_mismatch($sformatf("tx_valid %0b, want %0b", got.tx_valid, exp.tx_valid));
         if (got.last_byte !== exp.last_byte)
            report_mismatch($sformatf("last_byte %0b, want %0b", got.last_byte, exp.last_byte));
         if (got.break_seen !== exp.break_seen)
            report_mismatch($sformatf("break_seen %0b, want %0b", got.break_seen,
                                      exp.break_seen));
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [ID_W-1:0]   csr_wdata;

   lsr_req_if req_ch();
   lsr_rsp_if rsp_ch();

   lin_slave_responder_top #(
      .DATA_BYTES(SLOTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_ch),
      .rsp_if   (rsp_ch),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   lin_reply_tracker tracker = new();

   // Idle chances in percent. The main sequence sets them for each phase.
   int          send_idle_pct;
   int          stall_pct;
   int unsigned req_count;
   int unsigned reply_count;
   int unsigned quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver decides at every falling edge whether it takes a response transaction
   // on the next rising edge.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Response monitor and watchdog. Both sample at the rising edge. They see the values
   // from before the edge, and so do not depend on the order of processes.
   always @(posedge clock) begin : monitor_blk
      reply_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.tx_byte    = rsp_ch.tx_byte;
            got.tx_valid   = rsp_ch.tx_valid;
            got.last_byte  = rsp_ch.last_byte;
            got.break_seen = rsp_ch.break_seen;
            tracker.check_reply(got);
            reply_count++;
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
                     quiet_cycles, tracker.pending_replies.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   // Presents one request transaction. It may first leave some idle cycles, and then holds
   // the request until the block accepts it. Each falling edge gets one assignment at most,
   // so valid stays high between requests that follow each other directly.
   task automatic send_req(input req_item_type it);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.func          <= it.func;
      req_ch.rx_byte       <= it.rx_byte;
      req_ch.framing_error <= it.framing_error;
      req_ch.slot_index    <= it.slot_index;
      req_ch.slot_value    <= it.slot_value;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_request(it);
      req_count++;
   endtask

   // A received UART byte. The slot fields carry random values that the block must ignore.
   task automatic send_rx(input logic [BYTE_W-1:0] b, input logic fe);
      req_item_type it;
      it.func          = FUNC_RX_BYTE;
      it.rx_byte       = b;
      it.framing_error = fe;
      it.slot_index    = SLOT_W'($urandom_range(3));
      it.slot_value    = BYTE_W'($urandom_range(255));
      send_req(it);
   endtask

   // A write to a data slot. The receive fields carry random values that the block must ignore.
   task automatic send_slot(input logic [SLOT_W-1:0] idx, input logic [BYTE_W-1:0] val);
      req_item_type it;
      it.func          = FUNC_SLOT_WRITE;
      it.rx_byte       = BYTE_W'($urandom_range(255));
      it.framing_error = 1'($urandom_range(1));
      it.slot_index    = idx;
      it.slot_value    = val;
      send_req(it);
   endtask

   // Drops valid at the falling edge just after the last accepted request, so that
   // the request is not taken a second time.
   task automatic end_burst();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // Waits until every predicted response has arrived, then lets the block settle.
   task automatic wait_drained();
      while (tracker.pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Register write. It is only made while the block is idle.
   task automatic set_node_id(input logic [ID_W-1:0] id);
      wait_drained();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= id;
      tracker.node_id = id;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Random traffic. Most of it is well-formed frames with random content, so that
   // the PID phase and the answer path get plenty of use. The rest is broken frames,
   // slot writes and loose bytes.
   task automatic run_traffic(input int unsigned n);
      int unsigned issued;
      int unsigned pick;
      logic [BYTE_W-1:0] pid;
      issued = 0;
      while (issued < n) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_rx(BYTE_W'($urandom_range(255)), 1'b1);
            if ($urandom_range(4) == 0) begin
               send_slot(SLOT_W'($urandom_range(3)), BYTE_W'($urandom_range(255)));
               issued++;
            end
            // The framing-error flag is random here because it must not matter after a break.
            send_rx(SYNC_BYTE, 1'($urandom_range(1)));
            if ($urandom_range(9) < 8) pid = tracker.pid_for(tracker.node_id);
            else pid = BYTE_W'($urandom_range(255));
            send_rx(pid, 1'($urandom_range(1)));
            issued += 3;
         end else if (pick < 70) begin
            // Broken frame: a bad sync, or a good sync followed by a near-miss PID.
            send_rx(BYTE_W'($urandom_range(255)), 1'b1);
            if ($urandom_range(1) == 0) begin
               send_rx(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
               issued += 2;
            end else begin
               send_rx(SYNC_BYTE, 1'($urandom_range(1)));
               pid = tracker.pid_for(tracker.node_id) ^ (8'h01 << $urandom_range(7));
               send_rx(pid, 1'($urandom_range(1)));
               issued += 3;
            end
         end else if (pick < 85) begin
            send_slot(SLOT_W'($urandom_range(3)), BYTE_W'($urandom_range(255)));
            issued++;
         end else begin
            send_rx(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
            issued++;
         end
      end
   endtask

   initial begin : main_seq
      int unsigned phase_no;
      logic [ID_W-1:0] next_id;

      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.func          = FUNC_RX_BYTE;
      req_ch.rx_byte       = '0;
      req_ch.framing_error = 1'b0;
      req_ch.slot_index    = '0;
      req_ch.slot_value    = '0;
      send_idle_pct        = 0;
      stall_pct            = 0;
      req_count            = 0;
      reply_count          = 0;
      quiet_cycles         = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with node id 0, whose PID is 8'h80, and no idling.
      set_node_id('0);
      // Every slot at its maximum, so that the checksum carries on every addition.
      send_slot(2'd0, 8'hFF);
      send_slot(2'd1, 8'hFF);
      send_slot(2'd2, 8'hFF);
      send_slot(2'd3, 8'hFF);
      // A sync byte without a break is ignored while the slave waits for a break.
      send_rx(SYNC_BYTE, 1'b0);
      // Break, then a sync and a matching PID that both carry a framing error. The flag
      // must not matter once the break has been seen.
      send_rx(8'h00, 1'b1);
      send_rx(SYNC_BYTE, 1'b1);
      send_rx(tracker.pid_for('0), 1'b1);
      // A wrong sync byte returns to break wait. The PID that follows is then ignored.
      send_rx(8'hFF, 1'b1);
      send_rx(8'h54, 1'b0);
      send_rx(tracker.pid_for('0), 1'b0);
      // A byte equal to the sync byte but with a framing error counts as a break.
      send_rx(SYNC_BYTE, 1'b1);
      send_rx(SYNC_BYTE, 1'b0);
      // Wrong PID: the raw id without its parity bits.
      send_rx(8'h00, 1'b0);
      // Slot writes in the middle of a frame leave the phase alone and feed the answer.
      send_rx(8'hA5, 1'b1);
      send_slot(2'd0, 8'h00);
      send_rx(SYNC_BYTE, 1'b0);
      send_slot(2'd3, 8'h01);
      send_rx(tracker.pid_for('0), 1'b0);
      end_burst();
      wait_drained();

      // Random phases. Each one has its own idle pattern and node id, among them
      // both extremes of the id.
      for (phase_no = 0; phase_no < 4; phase_no++) begin
         case (phase_no)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
               next_id       = '1;
            end
            1: begin
               send_idle_pct = 84;
               stall_pct     = 0;
               next_id       = ID_W'($urandom_range(62, 1));
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 84;
               next_id       = ID_W'($urandom_range(62, 1));
            end
            default: begin
               send_idle_pct = 16;
               stall_pct     = 16;
               next_id       = '0;
            end
         endcase
         set_node_id(next_id);
         run_traffic(55);
         end_burst();
         wait_drained();
      end

      $display("run covered %0d request and %0d response transactions", req_count, reply_count);
      $display("frames answered %0d, breaks reported %0d, across five node id settings",
               tracker.frames_answered, tracker.breaks_seen);
      if (tracker.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("mismatches counted: %0d", tracker.errors);
         $display("status: fail");
      end
      $finish;
   end

endmodule
